/* rtl/brct_pkg.sv */
// brct_pkg: shared types and constants for the byte range coverage tracker
// used by brct_cell and byte_range_coverage_tracker_core
`default_nettype none

package brct_pkg;

   localparam int MaxIntervals = 64;
   localparam int CountWidth   = $clog2(MaxIntervals + 1);

   localparam logic [1:0] CmdRecord    = 2'd0;
   localparam logic [1:0] CmdQuery     = 2'd1;
   localparam logic [1:0] CmdInterrupt = 2'd2;

   // query range broadcast to every cell
   typedef struct packed {
      logic [63:0] off;
      logic [63:0] limit;
      logic [63:0] last;
   } qry_type;

   // running sum handed from cell to cell
   typedef struct packed {
      logic        tok;
      logic        hit;
      logic [63:0] total;
   } link_type;

endpackage

`default_nettype wire

/* rtl/brct_cell.sv */
// brct_cell: one stored interval, its coverage term and one link of the sum chain
// depends on brct_pkg
`default_nettype none

module brct_cell
   import brct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire logic [63:0] wr_start,
   input  wire logic [63:0] wr_end,
   input  wire logic        used,
   input  wire logic        term_en,
   input  wire qry_type     qry,
   input  wire link_type    link_in,
   output link_type         link_out
);

   logic [63:0] start_ff;
   logic [63:0] end_ff;
   logic [63:0] term_ff;
   logic [63:0] term_in;
   logic        encl_ff;
   logic        encl_in;
   link_type    link_ff;
   link_type    link_in_next;
   logic [63:0] clip_end;
   logic [64:0] sum;

   always_comb begin
      clip_end = (end_ff < qry.last) ? end_ff : qry.last;
      term_in  = '0;
      encl_in  = 1'b0;
      if (used) begin
         priority if (start_ff >= qry.off && start_ff < qry.limit) begin
            term_in = clip_end - start_ff + 64'd1;
         end else if (end_ff >= qry.off && end_ff < qry.limit) begin
            term_in = end_ff - qry.off + 64'd1;
         end else if (start_ff < qry.off && end_ff >= qry.limit) begin
            encl_in = 1'b1;
         end else begin
            term_in = '0;
         end
      end
   end

   always_comb begin
      sum                = {1'b0, link_in.total} + {1'b0, term_ff};
      link_in_next.tok   = link_in.tok;
      link_in_next.hit   = link_in.hit | encl_ff;
      link_in_next.total = sum[64] ? '1 : sum[63:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_ff <= wr_start;
         end_ff   <= wr_end;
      end
      if (term_en) begin
         term_ff <= term_in;
         encl_ff <= encl_in;
      end
      link_ff.hit   <= link_in_next.hit;
      link_ff.total <= link_in_next.total;
      if (reset) begin
         link_ff.tok <= 1'b0;
      end else begin
         link_ff.tok <= link_in_next.tok;
      end
   end

   assign link_out = link_ff;

endmodule

`default_nettype wire

/* rtl/byte_range_coverage_tracker_core.sv */
// byte_range_coverage_tracker_core: top level, command decode, chain of interval cells
// depends on brct_pkg and brct_cell
//
// Usage: items arrive on the req_ channel (cmd, offset, length) and each gives one
// result on the rsp_ channel (available, interrupted, table_full). A transfer takes
// place on a rising edge with valid high and stall low.
// Record and interrupt items finish in the transfer cycle: the result is presented
// in the next cycle, and a new item may be taken at once while the result is free
// to leave.
// A query loads the range, lets every cell work out its coverage term in StTerm,
// then sends a running sum down the row of 64 cells, one cell per cycle. The result
// is presented once the sum has left the last cell and the rsp_ channel is free;
// no new item is taken before that, and the walk length is set by the cell count.
// Only one item is in the block at a time; req_stall is high while a query walks
// and while a result waits on a stalled rsp_ channel.
// Reset empties the interval table and clears the interrupt flag and any pending
// result; stored interval contents are not cleared. A stalled result holds its
// fields until taken.
`default_nettype none

module byte_range_coverage_tracker_core
   import brct_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_offset,
   input  wire logic [63:0] req_length,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_available,
   output logic             rsp_interrupted,
   output logic             rsp_table_full
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StTerm   = 3'd1;
   localparam logic [2:0] StInject = 3'd2;
   localparam logic [2:0] StWalk   = 3'd3;
   localparam logic [2:0] StDone   = 3'd4;

   logic [2:0]            state_ff;
   logic [2:0]            state_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  intr_ff;
   logic                  intr_in;
   qry_type               qry_ff;
   logic [63:0]           len_ff;
   logic                  avail_ff;
   logic                  avail_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_avail_ff;
   logic                  rsp_avail_in;
   logic                  rsp_intr_ff;
   logic                  rsp_intr_in;
   logic                  rsp_full_ff;
   logic                  rsp_full_in;
   logic                  rsp_free;
   logic                  accept;
   logic                  rec_write;
   logic [63:0]           wr_end;
   link_type              link [0:MaxIntervals];

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == StIdle && rsp_free);
   assign accept    = req_valid && !req_stall;
   assign rec_write = accept && req_cmd == CmdRecord
                      && count_ff < CountWidth'(MaxIntervals);
   assign wr_end    = req_offset + req_length - 64'd1;

   assign link[0].tok   = (state_ff == StInject);
   assign link[0].hit   = 1'b0;
   assign link[0].total = '0;

   for (genvar i = 0; i < MaxIntervals; i++) begin : g_cell
      brct_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (rec_write && count_ff == CountWidth'(i)),
         .wr_start (req_offset),
         .wr_end   (wr_end),
         .used     (count_ff > CountWidth'(i)),
         .term_en  (state_ff == StTerm),
         .qry      (qry_ff),
         .link_in  (link[i]),
         .link_out (link[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      intr_in      = intr_ff;
      avail_in     = avail_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_avail_in = rsp_avail_ff;
      rsp_intr_in  = rsp_intr_ff;
      rsp_full_in  = rsp_full_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               unique case (req_cmd)
                  CmdRecord: begin
                     rsp_valid_in = 1'b1;
                     rsp_avail_in = 1'b0;
                     rsp_intr_in  = intr_ff;
                     rsp_full_in  = !rec_write;
                     if (rec_write) begin
                        count_in = count_ff + CountWidth'(1);
                     end
                  end
                  CmdQuery: begin
                     state_in = StTerm;
                  end
                  CmdInterrupt: begin
                     intr_in      = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_avail_in = 1'b0;
                     rsp_intr_in  = 1'b1;
                     rsp_full_in  = 1'b0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_avail_in = 1'b0;
                     rsp_intr_in  = intr_ff;
                     rsp_full_in  = 1'b0;
                  end
               endcase
            end
         end
         StTerm: begin
            state_in = StInject;
         end
         StInject: begin
            state_in = StWalk;
         end
         StWalk: begin
            if (link[MaxIntervals].tok) begin
               avail_in = !intr_ff && (link[MaxIntervals].hit
                                       || link[MaxIntervals].total >= len_ff);
               state_in = StDone;
            end
         end
         StDone: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_avail_in = avail_ff;
               rsp_intr_in  = intr_ff;
               rsp_full_in  = 1'b0;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && req_cmd == CmdQuery) begin
         qry_ff.off   <= req_offset;
         qry_ff.limit <= req_offset + req_length;
         qry_ff.last  <= wr_end;
         len_ff       <= req_length;
      end
      avail_ff     <= avail_in;
      rsp_avail_ff <= rsp_avail_in;
      rsp_intr_ff  <= rsp_intr_in;
      rsp_full_ff  <= rsp_full_in;
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         intr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         intr_ff      <= intr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_available   = rsp_avail_ff;
   assign rsp_interrupted = rsp_intr_ff;
   assign rsp_table_full  = rsp_full_ff;

endmodule

`default_nettype wire
